/* hdl/ascii_coordinate_frame_parser_defines.svh */
// Assertion macros for the coordinate frame parser.
`ifndef ASCII_COORDINATE_FRAME_PARSER_DEFINES_SVH
`define ASCII_COORDINATE_FRAME_PARSER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ACFP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ACFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/acfp_pkg.sv */
// Shared types and constants of the coordinate frame parser.
package acfp_pkg;

   localparam logic [7:0] HDR_LINE  = 8'h73;
   localparam logic [7:0] HDR_QR    = 8'h66;
   localparam logic [7:0] HDR_BLOB  = 8'h62;
   localparam logic [15:0] ZERO_CHAR = 16'd48;
   localparam logic [15:0] HUNDRED   = 16'd100;
   localparam logic [15:0] TEN       = 16'd10;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_LINE = 2'd1;
   localparam logic [1:0] MODE_QR   = 2'd2;
   localparam logic [1:0] MODE_BLOB = 2'd3;
   localparam logic [1:0] MODE_RESET = MODE_LINE;

   localparam logic [2:0] KIND_LINE_X = 3'd0;
   localparam logic [2:0] KIND_LINE_Y = 3'd1;
   localparam logic [2:0] KIND_BLOB_X = 3'd2;
   localparam logic [2:0] KIND_BLOB_Y = 3'd3;
   localparam logic [2:0] KIND_QR     = 3'd4;

   localparam logic [3:0] POS_WAIT    = 4'd0;
   localparam logic [3:0] POS_1       = 4'd1;
   localparam logic [3:0] POS_2       = 4'd2;
   localparam logic [3:0] POS_3       = 4'd3;
   localparam logic [3:0] POS_4       = 4'd4;
   localparam logic [3:0] POS_5       = 4'd5;
   localparam logic [3:0] POS_6       = 4'd6;
   localparam logic [3:0] POS_7       = 4'd7;
   localparam logic [3:0] POS_QR_DONE = 4'd8;

   localparam logic [2:0] QR_LAST_INDEX = 3'd5;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } stage_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  value_kind;
      logic [2:0]  digit_index;
      logic [15:0] value;
   } result_type;

endpackage

/* hdl/acfp_req_if.sv */
// Byte input channel.
interface acfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* hdl/acfp_rsp_if.sv */
// Result output channel.
interface acfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         value_kind;
   logic [2:0]         digit_index;
   logic signed [15:0] value;

   modport source (output valid, output value_kind, output digit_index, output value,
                   input ready);
   modport sink (input valid, input value_kind, input digit_index, input value,
                 output ready);
endinterface

/* hdl/acfp_csr_if.sv */
// Parse mode write channel.
interface acfp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] parse_mode;

   modport source (output valid, output parse_mode, input ready);
   modport sink (input valid, input parse_mode, output ready);
endinterface

/* hdl/ascii_coordinate_frame_parser.sv */
// Top level of the ASCII coordinate frame parser.
// Each accepted byte is registered in the input register, and its result is
// registered in the result register. One byte per cycle is taken while results
// drain; a waiting result stalls the input once the input register holds a byte.
// Reset: parse mode returns to line coordinates, the frame waits for a header,
// the partial coordinate clears and both pipeline registers empty.
module ascii_coordinate_frame_parser (
   input  logic        clock,
   input  logic        reset,
   acfp_req_if.sink    req_channel,
   acfp_rsp_if.source  rsp_channel,
   acfp_csr_if.sink    csr_channel
);

   logic                 [1:0] mode_ff;
   logic                 [1:0] mode_in;
   logic                 advance;
   acfp_pkg::stage_type  stage;
   acfp_pkg::result_type result;

   assign csr_channel.ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_channel.valid) begin
         mode_in = csr_channel.parse_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= acfp_pkg::MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   acfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_rx_byte (req_channel.rx_byte),
      .req_ready   (req_channel.ready),
      .advance     (advance),
      .stage       (stage)
   );

   acfp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .stage     (stage),
      .advance   (advance),
      .rsp_ready (rsp_channel.ready),
      .result    (result)
   );

   assign rsp_channel.valid       = result.valid;
   assign rsp_channel.value_kind  = result.value_kind;
   assign rsp_channel.digit_index = result.digit_index;
   assign rsp_channel.value       = result.value;

endmodule

/* hdl/acfp_in_stage.sv */
// Input register that holds one byte while the result stage is stalled.
module acfp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_rx_byte,
   output logic                 req_ready,
   input  logic                 advance,
   output acfp_pkg::stage_type  stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

/* hdl/acfp_decode.sv */
// Frame state tracking, digit accumulation and result register.
`include "ascii_coordinate_frame_parser_defines.svh"

module acfp_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            mode,
   input  acfp_pkg::stage_type   stage,
   output logic                  advance,
   input  logic                  rsp_ready,
   output acfp_pkg::result_type  result
);

   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [15:0] part_ff;
   logic [15:0] part_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  kind_ff;
   logic [2:0]  kind_in;
   logic [2:0]  index_ff;
   logic [2:0]  index_in;
   logic [15:0] value_ff;
   logic [15:0] value_in;
   logic        emit;
   logic        step;
   logic [15:0] digit;
   logic [15:0] digit_x100;
   logic [15:0] digit_x10;
   logic [7:0]  header;
   logic [2:0]  kind_x;
   logic [7:0]  b;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign step       = stage.valid && advance;
   assign b          = stage.rx_byte;
   assign digit      = {8'h00, b} - acfp_pkg::ZERO_CHAR;
   assign digit_x100 = 16'(digit * acfp_pkg::HUNDRED);
   assign digit_x10  = 16'(digit * acfp_pkg::TEN);
   assign header     = (mode == acfp_pkg::MODE_LINE) ? acfp_pkg::HDR_LINE : acfp_pkg::HDR_BLOB;
   assign kind_x     = (mode == acfp_pkg::MODE_LINE) ? acfp_pkg::KIND_LINE_X
                                                     : acfp_pkg::KIND_BLOB_X;

   always_comb begin
      pos_in   = pos_ff;
      part_in  = part_ff;
      emit     = 1'b0;
      kind_in  = kind_x;
      index_in = 3'd0;
      value_in = 16'(part_ff + digit);
      unique case (mode)
         acfp_pkg::MODE_LINE, acfp_pkg::MODE_BLOB: begin
            if (b == header) begin
               pos_in = acfp_pkg::POS_1;
            end else begin
               case (pos_ff)
                  acfp_pkg::POS_1, acfp_pkg::POS_4: begin
                     part_in = digit_x100;
                     pos_in  = pos_ff + 4'd1;
                  end
                  acfp_pkg::POS_2, acfp_pkg::POS_5: begin
                     part_in = 16'(part_ff + digit_x10);
                     pos_in  = pos_ff + 4'd1;
                  end
                  acfp_pkg::POS_3: begin
                     part_in = value_in;
                     pos_in  = acfp_pkg::POS_4;
                     emit    = 1'b1;
                  end
                  acfp_pkg::POS_6: begin
                     part_in = value_in;
                     pos_in  = acfp_pkg::POS_WAIT;
                     emit    = 1'b1;
                     kind_in = kind_x + 3'd1;
                  end
                  default: begin
                     pos_in = acfp_pkg::POS_WAIT;
                  end
               endcase
            end
         end
         acfp_pkg::MODE_QR: begin
            kind_in  = acfp_pkg::KIND_QR;
            value_in = digit;
            if (b == acfp_pkg::HDR_QR) begin
               pos_in = acfp_pkg::POS_1;
            end else begin
               case (pos_ff)
                  acfp_pkg::POS_1, acfp_pkg::POS_2, acfp_pkg::POS_3: begin
                     index_in = 3'(pos_ff - 4'd1);
                     pos_in   = pos_ff + 4'd1;
                     emit     = 1'b1;
                  end
                  acfp_pkg::POS_4: begin
                     pos_in = acfp_pkg::POS_5;
                  end
                  acfp_pkg::POS_5, acfp_pkg::POS_6, acfp_pkg::POS_7: begin
                     index_in = 3'(pos_ff - 4'd2);
                     pos_in   = pos_ff + 4'd1;
                     emit     = 1'b1;
                  end
                  default: begin
                     pos_in = acfp_pkg::POS_WAIT;
                  end
               endcase
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= acfp_pkg::POS_WAIT;
         part_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            pos_ff  <= pos_in;
            part_ff <= part_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         kind_ff  <= kind_in;
         index_ff <= index_in;
         value_ff <= value_in;
      end
   end

   assign result.valid       = rsp_valid_ff;
   assign result.value_kind  = kind_ff;
   assign result.digit_index = index_ff;
   assign result.value       = value_ff;

   `ACFP_ASSERT_NOW(pos_bound_a, clock, reset, 1'b1, pos_ff <= acfp_pkg::POS_QR_DONE, "position out of range")
   `ACFP_ASSERT_NOW(qr_index_a, clock, reset, rsp_valid_ff && kind_ff == acfp_pkg::KIND_QR, index_ff <= acfp_pkg::QR_LAST_INDEX, "QR digit index out of range")
   `ACFP_ASSERT_NOW(coord_index_a, clock, reset, rsp_valid_ff && kind_ff != acfp_pkg::KIND_QR, index_ff == 3'd0, "coordinate with nonzero index")
   `ACFP_ASSERT_NEXT(idle_hold_a, clock, reset, step && mode == acfp_pkg::MODE_IDLE, $stable(pos_ff) && $stable(part_ff), "idle mode changed frame state")
   `ACFP_ASSERT_NEXT(y_done_a, clock, reset, step && emit && (kind_in == acfp_pkg::KIND_LINE_Y || kind_in == acfp_pkg::KIND_BLOB_Y), pos_ff == acfp_pkg::POS_WAIT, "frame not closed after Y")

endmodule
